/* design/obk_pkg.sv */
// Shared types, codes and the priority compare for the order book.
// No dependencies; imported by obk_cell, obk_chain and price_time_order_book.
`default_nettype none
package obk_pkg;

    localparam int DEFAULT_BOOK_DEPTH = 64;

    localparam int ID_W    = 31;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 31;
    localparam int TIME_W  = 48;
    localparam int COUNT_OUT_W = 7;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0] op;
        entry_t     ent;
    } chain_ctl_t;

    typedef struct packed {
        logic               found;
        logic               full;
        logic               top_valid;
        logic [PRICE_W-1:0] top_price;
    } chain_sts_t;

    // true if (pa,ta) stands strictly ahead of (pb,tb)
    function automatic logic ahead(input logic desc,
                                   input logic [PRICE_W-1:0] pa,
                                   input logic [TIME_W-1:0] ta,
                                   input logic [PRICE_W-1:0] pb,
                                   input logic [TIME_W-1:0] tb);
        logic r;
        if (pa != pb)
        begin
            r = desc ? (pa > pb) : (pa < pb);
        end
        else
        begin
            r = (ta < tb);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/price_time_order_book.sv */
// Price-time order book top: command decode around a bid and an ask obk_chain.
// Result: done is registered from start, or from a found modify's reinsert pass.
// Throughput: one command per cycle while busy is low; a found modify holds busy for
// its reinsert pass through the cell row. The receiver cannot stall results.
// Reset: both books empty, no result pending. Depends on obk_pkg, obk_chain.
`default_nettype none
module price_time_order_book #(
    parameter int BOOK_DEPTH = obk_pkg::DEFAULT_BOOK_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  command,
    input  wire logic [obk_pkg::ID_W-1:0]    order_id,
    input  wire logic                        side,
    input  wire logic [obk_pkg::PRICE_W-1:0] price,
    input  wire logic [obk_pkg::QTY_W-1:0]   quantity,
    input  wire logic [obk_pkg::TIME_W-1:0]  created_time,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [obk_pkg::COUNT_OUT_W-1:0]  buy_count,
    output logic [obk_pkg::COUNT_OUT_W-1:0]  sell_count,
    output logic                             best_bid_valid,
    output logic [obk_pkg::PRICE_W-1:0]      best_bid_price,
    output logic                             best_ask_valid,
    output logic [obk_pkg::PRICE_W-1:0]      best_ask_price
);
    import obk_pkg::*;

    localparam int COUNT_W = $clog2(BOOK_DEPTH + 1);

    chain_ctl_t bid_ctl, ask_ctl;
    chain_sts_t bid_sts, ask_sts;
    logic [COUNT_W-1:0] bid_count, ask_count;

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [1:0] status_reg, status_next;
    logic ins_side_reg, ins_side_next;
    logic [PRICE_W-1:0] mod_price_reg;
    logic [QTY_W-1:0]   mod_qty_reg;
    entry_t cmd_ent;

    always_comb
    begin
        cmd_ent.id    = order_id;
        cmd_ent.price = busy_reg ? mod_price_reg : price;
        cmd_ent.qty   = busy_reg ? mod_qty_reg : quantity;
        cmd_ent.stamp = created_time;
        bid_ctl.ent   = cmd_ent;
        ask_ctl.ent   = cmd_ent;
        bid_ctl.op    = OP_NOP;
        ask_ctl.op    = OP_NOP;
        status_next   = status_reg;
        done_next     = 1'b0;
        busy_next     = 1'b0;
        ins_side_next = ins_side_reg;
        if (busy_reg)
        begin
            // reinsert the modified entry
            if (ins_side_reg)
            begin
                ask_ctl.op = OP_INSERT;
            end
            else
            begin
                bid_ctl.op = OP_INSERT;
            end
            status_next = ST_DONE;
            done_next   = 1'b1;
        end
        else if (start)
        begin
            done_next   = 1'b1;
            status_next = ST_DONE;
            unique case (command)
                CMD_ADD:
                begin
                    if (side ? ask_sts.full : bid_sts.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (side)
                    begin
                        ask_ctl.op = OP_ADD;
                    end
                    else
                    begin
                        bid_ctl.op = OP_ADD;
                    end
                end
                CMD_CANCEL, CMD_MODIFY:
                begin
                    if (bid_sts.found || ask_sts.found)
                    begin
                        if (bid_sts.found)
                        begin
                            bid_ctl.op = OP_REMOVE;
                        end
                        else
                        begin
                            ask_ctl.op = OP_REMOVE;
                        end
                        ins_side_next = ~bid_sts.found;
                        if (command == CMD_MODIFY)
                        begin
                            busy_next = 1'b1;
                            done_next = 1'b0;
                        end
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                CMD_CLEAR:
                begin
                    bid_ctl.op = OP_CLEAR;
                    ask_ctl.op = OP_CLEAR;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_DONE;
            ins_side_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            ins_side_reg <= ins_side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            mod_price_reg <= price;
            mod_qty_reg   <= quantity;
        end
    end

    obk_chain #(.BOOK_DEPTH(BOOK_DEPTH), .DESCENDING(1'b1), .COUNT_W(COUNT_W)) u_bid (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (bid_ctl),
        .sts  (bid_sts),
        .count(bid_count)
    );

    obk_chain #(.BOOK_DEPTH(BOOK_DEPTH), .DESCENDING(1'b0), .COUNT_W(COUNT_W)) u_ask (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ask_ctl),
        .sts  (ask_sts),
        .count(ask_count)
    );

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign buy_count      = COUNT_OUT_W'(bid_count);
    assign sell_count     = COUNT_OUT_W'(ask_count);
    assign best_bid_valid = bid_sts.top_valid;
    assign best_bid_price = bid_sts.top_price;
    assign best_ask_valid = ask_sts.top_valid;
    assign best_ask_price = ask_sts.top_price;

endmodule
`default_nettype wire

/* design/obk_cell.sv */
// One slot of a sorted book: holds an entry, shifts with its neighbors.
// Depends on obk_pkg.
`default_nettype none
module obk_cell #(
    parameter logic DESCENDING = 1'b1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire obk_pkg::chain_ctl_t ctl,
    input  wire obk_pkg::entry_t new_ent,
    input  wire obk_pkg::entry_t left_ent,
    input  wire logic            left_valid,
    input  wire logic            left_cond,
    input  wire obk_pkg::entry_t right_ent,
    input  wire logic            right_valid,
    input  wire logic            hit_in,
    output obk_pkg::entry_t      ent,
    output logic                 valid,
    output logic                 cond,
    output logic                 hit_out,
    output logic                 first_hit
);
    import obk_pkg::*;

    entry_t ent_reg;
    logic   valid_reg;
    logic   lt_reg;
    logic   match;
    logic   use_lt;

    assign match     = valid_reg && (ent_reg.id == ctl.ent.id);
    assign hit_out   = hit_in | match;
    assign first_hit = match & ~hit_in;
    assign use_lt    = (ctl.op == OP_ADD) || lt_reg;
    // insert point: first slot that is empty or falls behind the new entry
    assign cond = !valid_reg ||
        (use_lt ? ahead(DESCENDING, new_ent.price, new_ent.stamp,
                        ent_reg.price, ent_reg.stamp)
                : !ahead(DESCENDING, ent_reg.price, ent_reg.stamp,
                         new_ent.price, new_ent.stamp));

    assign ent   = ent_reg;
    assign valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b1;
        end
        else
        begin
            unique case (ctl.op)
                OP_ADD, OP_INSERT:
                begin
                    if (left_cond)
                    begin
                        valid_reg <= left_valid;
                    end
                    else if (cond)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (hit_out)
                    begin
                        valid_reg <= right_valid;
                    end
                    lt_reg <= ~hit_out;
                end
                OP_CLEAR:
                begin
                    valid_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_ADD, OP_INSERT:
            begin
                if (left_cond)
                begin
                    ent_reg <= left_ent;
                end
                else if (cond)
                begin
                    ent_reg <= new_ent;
                end
            end
            OP_REMOVE:
            begin
                if (hit_out)
                begin
                    ent_reg <= right_ent;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/obk_chain.sv */
// One sorted book: a row of obk_cell slots, fill count and removed-entry hold.
// Depends on obk_pkg and obk_cell.
`default_nettype none
module obk_chain #(
    parameter int   BOOK_DEPTH = obk_pkg::DEFAULT_BOOK_DEPTH,
    parameter logic DESCENDING = 1'b1,
    parameter int   COUNT_W    = $clog2(BOOK_DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire obk_pkg::chain_ctl_t ctl,
    output obk_pkg::chain_sts_t      sts,
    output logic [COUNT_W-1:0]       count
);
    import obk_pkg::*;

    entry_t             ent_w   [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] valid_w;
    logic [BOOK_DEPTH-1:0] cond_w;
    logic [BOOK_DEPTH-1:0] first_w;
    logic [BOOK_DEPTH:0]   hit_w;
    entry_t             new_ent;
    entry_t             hold_reg;
    entry_t             hold_next;
    logic [COUNT_W-1:0] count_reg;

    assign hit_w[0] = 1'b0;

    always_comb
    begin
        new_ent = ctl.ent;
        if (ctl.op == OP_INSERT)
        begin
            new_ent.id    = hold_reg.id;
            new_ent.stamp = hold_reg.stamp;
        end
    end

    for (genvar i = 0; i < BOOK_DEPTH; i++)
    begin : g_cell
        entry_t l_ent, r_ent;
        logic   l_valid, l_cond, r_valid;
        if (i == 0)
        begin : g_first
            assign l_ent   = new_ent;
            assign l_valid = 1'b0;
            assign l_cond  = 1'b0;
        end
        else
        begin : g_mid
            assign l_ent   = ent_w[i-1];
            assign l_valid = valid_w[i-1];
            assign l_cond  = cond_w[i-1];
        end
        if (i == BOOK_DEPTH - 1)
        begin : g_last
            assign r_ent   = new_ent;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner
            assign r_ent   = ent_w[i+1];
            assign r_valid = valid_w[i+1];
        end
        obk_cell #(.DESCENDING(DESCENDING)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_ent    (new_ent),
            .left_ent   (l_ent),
            .left_valid (l_valid),
            .left_cond  (l_cond),
            .right_ent  (r_ent),
            .right_valid(r_valid),
            .hit_in     (hit_w[i]),
            .ent        (ent_w[i]),
            .valid      (valid_w[i]),
            .cond       (cond_w[i]),
            .hit_out    (hit_w[i+1]),
            .first_hit  (first_w[i])
        );
    end

    // pick the first matching entry; at most one select bit is set
    always_comb
    begin
        hold_next = '0;
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            hold_next = hold_next | (first_w[i] ? ent_w[i] : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_REMOVE)
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                OP_ADD, OP_INSERT: count_reg <= count_reg + COUNT_W'(1);
                OP_REMOVE:         count_reg <= count_reg - COUNT_W'(1);
                OP_CLEAR:          count_reg <= '0;
                default:           count_reg <= count_reg;
            endcase
        end
    end

    assign count         = count_reg;
    assign sts.found     = hit_w[BOOK_DEPTH];
    assign sts.full      = (count_reg == COUNT_W'(BOOK_DEPTH));
    assign sts.top_valid = valid_w[0];
    assign sts.top_price = valid_w[0] ? ent_w[0].price : '0;

endmodule
`default_nettype wire
